/* hw/rtl/bnph_pkg.sv */
// Shared types and constants for the byte and nibble-pair histogram.
package bnph_pkg;

    localparam logic [1:0] CMD_COUNT = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    localparam logic [2:0] SEL_LO_NIB  = 3'd0;
    localparam logic [2:0] SEL_HI_NIB  = 3'd1;
    localparam logic [2:0] SEL_BYTE    = 3'd2;
    localparam logic [2:0] SEL_PAIR_LO = 3'd3;
    localparam logic [2:0] SEL_PAIR_HI = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ZERO    = 2'd1;
    localparam logic [1:0] ST_BAD_BIN = 2'd2;

    localparam logic [14:0] PERCENT_MAX = 15'd25600;
    localparam int          DIV_STEPS   = 16;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD_WAIT,
        S_RD_DATA,
        S_DIV,
        S_OUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic clr_we;     // write zero at clear address
        logic clr_start;  // reset clear address and pair state
        logic clr_step;   // advance clear address
        logic cnt_fire;   // count accepted byte
        logic rd_capture; // latch read request
        logic rd_load;    // load RAM data and start divide
        logic div_step;   // one long-division step
        logic out_load;   // load result register
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic clr_last;
        logic div_last;
        logic cnt_busy;   // pipeline write still pending
    } ctrl_status_t;

endpackage

/* hw/rtl/byte_nibble_pair_histogram_top.sv */
// Top level of the byte and nibble-pair histogram.
// Usage:
//  One valid/ready request channel (s_*): cmd 0 counts s_data_byte, cmd 1 reads
//  bin s_bin_index of table s_table_sel, cmd 2 clears all tables, cmd 3 is dropped.
//  Only reads produce a result on the m_* channel: count, percent, total, status.
//  Counting takes one request per cycle while idle; the table RAMs are updated by a
//  read-modify-write pipeline with forwarding between back-to-back bytes.
//  A read or clear waits for pending count writes to land.
//  A read passes the RAM read (S_RD_WAIT, S_RD_DATA), sixteen steps of the
//  bit-per-cycle long division of 100*count*bins by the total, and a load of the
//  result register. No request is taken while a read is in flight.
//  After reset and after a clear, a sweep over all 256 addresses zeroes the
//  tables; s_ready is low meanwhile.
//  If the receiver stalls, the result is held in the output register and the
//  next read's result waits for it to be taken; counting goes on while idle.
module byte_nibble_pair_histogram_top #(
    parameter int COUNT_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [7:0]  s_data_byte,
    input  logic [2:0]  s_table_sel,
    input  logic [7:0]  s_bin_index,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_bin_count,
    output logic [14:0] m_percent,
    output logic [31:0] m_total_bytes,
    output logic [1:0]  m_status
);
    bnph_pkg::ctrl_cmd_t    cmd;
    bnph_pkg::ctrl_status_t sts;

    bnph_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_cmd(s_cmd),
        .s_ready(s_ready), .m_valid(m_valid), .m_ready(m_ready),
        .sts(sts), .cmd(cmd)
    );

    bnph_datapath #(.COUNT_BITS(COUNT_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .s_data_byte(s_data_byte), .s_table_sel(s_table_sel),
        .s_bin_index(s_bin_index), .m_bin_count(m_bin_count),
        .m_percent(m_percent), .m_total_bytes(m_total_bytes), .m_status(m_status)
    );
endmodule

/* hw/rtl/bnph_ram.sv */
// Generic single-port-write, single-read RAM with registered read.
module bnph_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* hw/rtl/bnph_ctrl.sv */
// Controller state machine: clearing sweep, counting, read sequencing.
module bnph_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic [1:0]            s_cmd,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  bnph_pkg::ctrl_status_t sts,
    output bnph_pkg::ctrl_cmd_t   cmd
);
    bnph_pkg::state_t state_reg, state_next;
    logic             m_valid_reg, m_valid_next;
    logic             acc;

    assign acc = s_valid && s_ready;
    assign m_valid = m_valid_reg;

    // next state
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            bnph_pkg::S_CLEAR: begin
                if (sts.clr_last) begin
                    state_next = bnph_pkg::S_IDLE;
                end
            end
            bnph_pkg::S_IDLE: begin
                if (acc && s_cmd == bnph_pkg::CMD_CLEAR) begin
                    state_next = bnph_pkg::S_CLEAR;
                end else if (acc && s_cmd == bnph_pkg::CMD_READ) begin
                    state_next = bnph_pkg::S_RD_WAIT;
                end
            end
            bnph_pkg::S_RD_WAIT: state_next = bnph_pkg::S_RD_DATA;
            bnph_pkg::S_RD_DATA: state_next = bnph_pkg::S_DIV;
            bnph_pkg::S_DIV: begin
                if (sts.div_last) begin
                    state_next = bnph_pkg::S_OUT;
                end
            end
            bnph_pkg::S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    state_next   = bnph_pkg::S_IDLE;
                end
            end
            default: state_next = bnph_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            bnph_pkg::S_CLEAR: begin
                cmd.clr_we   = 1'b1;
                cmd.clr_step = 1'b1;
            end
            bnph_pkg::S_IDLE: begin
                // reads and clears wait for the last count write to land
                s_ready = !(sts.cnt_busy && s_cmd != bnph_pkg::CMD_COUNT);
                cmd.cnt_fire   = acc && s_cmd == bnph_pkg::CMD_COUNT;
                cmd.rd_capture = acc && s_cmd == bnph_pkg::CMD_READ;
                cmd.clr_start  = acc && s_cmd == bnph_pkg::CMD_CLEAR;
            end
            bnph_pkg::S_RD_DATA: cmd.rd_load = 1'b1;
            bnph_pkg::S_DIV:     cmd.div_step = 1'b1;
            bnph_pkg::S_OUT:     cmd.out_load = !m_valid_reg || m_ready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= bnph_pkg::S_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end
endmodule

/* hw/rtl/bnph_datapath.sv */
// Datapath: count tables, read-modify-write pipeline, divider, result register.
module bnph_datapath #(
    parameter int COUNT_BITS = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  bnph_pkg::ctrl_cmd_t    cmd,
    output bnph_pkg::ctrl_status_t sts,
    input  logic [7:0]             s_data_byte,
    input  logic [2:0]             s_table_sel,
    input  logic [7:0]             s_bin_index,
    output logic [31:0]            m_bin_count,
    output logic [14:0]            m_percent,
    output logic [31:0]            m_total_bytes,
    output logic [1:0]             m_status
);
    localparam logic [COUNT_BITS-1:0] CMAX = '1;
    localparam int RW = COUNT_BITS + 1;

    // ---- table storage: 0 lo nib, 1 hi nib, 2 byte, 3 pair lo, 4 pair hi
    logic [7:0]            raddr [5];
    logic [7:0]            waddr [5];
    logic [COUNT_BITS-1:0] wdata [5];
    logic [COUNT_BITS-1:0] rdata [5];
    logic                  we    [5];

    genvar g;
    generate
        for (g = 0; g < 5; g++) begin : g_tab
            if (g < 2) begin : g_nib
                bnph_ram #(.WIDTH(COUNT_BITS), .DEPTH(16)) u_ram (
                    .aclk(aclk), .we(we[g]), .waddr(waddr[g][3:0]),
                    .wdata(wdata[g]), .raddr(raddr[g][3:0]), .rdata(rdata[g]));
            end else begin : g_wide
                bnph_ram #(.WIDTH(COUNT_BITS), .DEPTH(256)) u_ram (
                    .aclk(aclk), .we(we[g]), .waddr(waddr[g]),
                    .wdata(wdata[g]), .raddr(raddr[g]), .rdata(rdata[g]));
            end
        end
    endgenerate

    // ---- clear sweep address
    logic [7:0] clr_addr_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clr_start) begin
            clr_addr_reg <= '0;
        end else if (cmd.clr_step) begin
            clr_addr_reg <= clr_addr_reg + 8'd1;
        end
    end
    assign sts.clr_last = clr_addr_reg == 8'hff;

    // ---- pair tracking and total
    logic                  odd_reg;
    logic [7:0]            pend_reg;
    logic [COUNT_BITS-1:0] total_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clr_start) begin
            odd_reg   <= 1'b0;
            pend_reg  <= '0;
            total_reg <= '0;
        end else if (cmd.cnt_fire) begin
            odd_reg <= !odd_reg;
            if (!odd_reg) begin
                pend_reg <= s_data_byte;
            end
            if (total_reg != CMAX) begin
                total_reg <= total_reg + 1'b1;
            end
        end
    end

    // ---- count pipeline: accepted byte issues reads, stage 1 increments, stage 2 writes, stage 3 keeps for forwarding
    logic       p1_v_reg;
    logic [4:0] p1_en_reg;
    logic [7:0] p1_a_reg [5];
    logic       p2_v_reg;
    logic [4:0] p2_en_reg;
    logic [7:0] p2_a_reg [5];
    logic [COUNT_BITS-1:0] p2_d_reg [5];
    logic       p3_v_reg;
    logic [4:0] p3_en_reg;
    logic [7:0] p3_a_reg [5];
    logic [COUNT_BITS-1:0] p3_d_reg [5];
    logic [7:0] c_addr [5];
    logic [COUNT_BITS-1:0] cur [5];
    logic [COUNT_BITS-1:0] inc [5];

    assign c_addr[0] = {4'd0, s_data_byte[3:0]};
    assign c_addr[1] = {4'd0, s_data_byte[7:4]};
    assign c_addr[2] = s_data_byte;
    assign c_addr[3] = pend_reg;
    assign c_addr[4] = s_data_byte;

    // forward from the write stage, or from the write that landed as the RAM was read
    always_comb begin
        for (int t = 0; t < 5; t++) begin
            if (p2_v_reg && p2_en_reg[t] && p2_a_reg[t] == p1_a_reg[t]) begin
                cur[t] = p2_d_reg[t];
            end else if (p3_v_reg && p3_en_reg[t] && p3_a_reg[t] == p1_a_reg[t]) begin
                cur[t] = p3_d_reg[t];
            end else begin
                cur[t] = rdata[t];
            end
            inc[t] = (cur[t] == CMAX) ? cur[t] : cur[t] + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clr_start) begin
            p1_v_reg <= 1'b0;
            p2_v_reg <= 1'b0;
            p3_v_reg <= 1'b0;
        end else begin
            p1_v_reg <= cmd.cnt_fire;
            p2_v_reg <= p1_v_reg;
            p3_v_reg <= p2_v_reg;
        end
        p1_en_reg <= {odd_reg, odd_reg, 3'b111};
        p2_en_reg <= p1_en_reg;
        p3_en_reg <= p2_en_reg;
        for (int t = 0; t < 5; t++) begin
            p1_a_reg[t] <= c_addr[t];
            p2_a_reg[t] <= p1_a_reg[t];
            p2_d_reg[t] <= inc[t];
            p3_a_reg[t] <= p2_a_reg[t];
            p3_d_reg[t] <= p2_d_reg[t];
        end
    end
    assign sts.cnt_busy = p1_v_reg || p2_v_reg;

    // ---- read request latch
    logic [2:0] sel_reg;
    logic [7:0] bin_reg;
    always_ff @(posedge aclk) begin
        if (cmd.rd_capture) begin
            sel_reg <= s_table_sel;
            bin_reg <= s_bin_index;
        end
    end

    // RAM port muxing
    always_comb begin
        for (int t = 0; t < 5; t++) begin
            we[t]    = cmd.clr_we || (p2_v_reg && p2_en_reg[t]);
            waddr[t] = cmd.clr_we ? clr_addr_reg : p2_a_reg[t];
            wdata[t] = cmd.clr_we ? '0 : p2_d_reg[t];
            raddr[t] = cmd.cnt_fire ? c_addr[t] : bin_reg;
        end
    end

    // ---- read evaluation and long division: one quotient bit per step
    logic                  bad;
    logic [COUNT_BITS-1:0] sel_cnt;
    always_comb begin
        bad = sel_reg > bnph_pkg::SEL_PAIR_HI ||
              (sel_reg < bnph_pkg::SEL_BYTE && bin_reg > 8'd15);
        case (sel_reg)
            bnph_pkg::SEL_LO_NIB:  sel_cnt = rdata[0];
            bnph_pkg::SEL_HI_NIB:  sel_cnt = rdata[1];
            bnph_pkg::SEL_BYTE:    sel_cnt = rdata[2];
            bnph_pkg::SEL_PAIR_LO: sel_cnt = rdata[3];
            bnph_pkg::SEL_PAIR_HI: sel_cnt = rdata[4];
            default:               sel_cnt = '0;
        endcase
        if (bad) begin
            sel_cnt = '0;
        end
    end

    logic [COUNT_BITS-1:0] cnt_reg, num_reg;
    logic [15:0]           scale_reg, q_reg;
    logic [RW-1:0]         r_reg;
    logic [3:0]            step_reg;
    logic [1:0]            st_reg;
    logic                  pair_reg;
    logic [RW-1:0]         r2, s;
    logic [RW-1:0]         den;
    logic                  qb1, qb2;

    assign den = {1'b0, total_reg};
    always_comb begin
        r2  = {r_reg[RW-2:0], 1'b0};
        qb1 = r2 >= den;
        if (qb1) begin
            r2 = r2 - den;
        end
        s   = scale_reg[15] ? r2 + {1'b0, num_reg} : r2;
        qb2 = s >= den;
        if (qb2) begin
            s = s - den;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_load) begin
            cnt_reg   <= sel_cnt;
            num_reg   <= (sel_cnt > total_reg) ? total_reg : sel_cnt;
            scale_reg <= (sel_reg < bnph_pkg::SEL_BYTE) ? 16'd1600 : 16'd25600;
            pair_reg  <= sel_reg >= bnph_pkg::SEL_PAIR_LO;
            q_reg     <= '0;
            r_reg     <= '0;
            step_reg  <= '0;
            st_reg    <= bad ? bnph_pkg::ST_BAD_BIN :
                         (total_reg == '0) ? bnph_pkg::ST_ZERO : bnph_pkg::ST_OK;
        end else if (cmd.div_step) begin
            q_reg     <= {q_reg[14:0], 1'b0} + {15'd0, qb1} + {15'd0, qb2};
            r_reg     <= s;
            scale_reg <= {scale_reg[14:0], 1'b0};
            step_reg  <= step_reg + 4'd1;
        end
    end
    assign sts.div_last = step_reg == 4'(bnph_pkg::DIV_STEPS - 1);

    // ---- result register
    logic [16:0] pct;
    always_comb begin
        pct = pair_reg ? {q_reg, 1'b0} : {1'b0, q_reg};
        if (st_reg != bnph_pkg::ST_OK) begin
            pct = '0;
        end else if (pct > 17'(bnph_pkg::PERCENT_MAX)) begin
            pct = 17'(bnph_pkg::PERCENT_MAX);
        end
    end

    function automatic logic [31:0] clip32(input logic [COUNT_BITS-1:0] v);
        logic [COUNT_BITS+31:0] w;
        w = {32'd0, v};
        return (w > {{COUNT_BITS{1'b0}}, 32'hffffffff}) ? 32'hffffffff : w[31:0];
    endfunction

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_bin_count   <= clip32(cnt_reg);
            m_percent     <= pct[14:0];
            m_total_bytes <= clip32(total_reg);
            m_status      <= st_reg;
        end
    end
endmodule

/* tb/sv/histogram_checker.sv */
// Checker for the byte and nibble-pair histogram: predicts read results and compares them.
`timescale 1ns / 100ps
module histogram_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [7:0]  s_data_byte,
    input  logic [2:0]  s_table_sel,
    input  logic [7:0]  s_bin_index,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_bin_count,
    input  logic [14:0] m_percent,
    input  logic [31:0] m_total_bytes,
    input  logic [1:0]  m_status,
    output int          errors,
    output int          pending
);

    typedef struct packed {
        logic [31:0] count;
        logic [14:0] pct;
        logic [31:0] total;
        logic [1:0]  status;
    } read_result_t;

    // predicted histogram state
    logic [31:0] lo_nib_cnt [16];
    logic [31:0] hi_nib_cnt [16];
    logic [31:0] byte_cnt   [256];
    logic [31:0] plo_cnt    [256];
    logic [31:0] phi_cnt    [256];
    logic [31:0] total_cnt;
    logic [7:0]  open_low;
    logic        odd_pos;

    read_result_t expected_reads [$];

    assign pending = expected_reads.size();

    function automatic logic [31:0] sat_inc(logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    task automatic clear_tables();
        for (int i = 0; i < 256; i++) begin
            byte_cnt[i] = '0;
            plo_cnt[i] = '0;
            phi_cnt[i] = '0;
            if (i < 16) begin
                lo_nib_cnt[i] = '0;
                hi_nib_cnt[i] = '0;
            end
        end
        total_cnt = '0;
        open_low = '0;
        odd_pos = 1'b0;
    endtask

    function automatic read_result_t predict_read(logic [2:0] sel, logic [7:0] bin);
        read_result_t r;
        logic [31:0]  c;
        logic [63:0]  q;
        int           nbins;
        r = '0;
        r.total = total_cnt;
        if (sel > bnph_pkg::SEL_PAIR_HI || (sel < bnph_pkg::SEL_BYTE && bin > 8'd15)) begin
            r.status = bnph_pkg::ST_BAD_BIN;
            return r;
        end
        case (sel)
            bnph_pkg::SEL_LO_NIB:  c = lo_nib_cnt[bin[3:0]];
            bnph_pkg::SEL_HI_NIB:  c = hi_nib_cnt[bin[3:0]];
            bnph_pkg::SEL_BYTE:    c = byte_cnt[bin];
            bnph_pkg::SEL_PAIR_LO: c = plo_cnt[bin];
            default:               c = phi_cnt[bin];
        endcase
        r.count = c;
        if (total_cnt == 0) begin
            r.status = bnph_pkg::ST_ZERO;
            return r;
        end
        nbins = (sel < bnph_pkg::SEL_BYTE) ? 16 : 256;
        if (c > total_cnt) c = total_cnt;
        q = (64'(c) * 64'(100 * nbins)) / 64'(total_cnt);
        if (sel >= bnph_pkg::SEL_PAIR_LO) q = q * 2;
        if (q > 64'(bnph_pkg::PERCENT_MAX)) q = 64'(bnph_pkg::PERCENT_MAX);
        r.pct = q[14:0];
        r.status = bnph_pkg::ST_OK;
        return r;
    endfunction

    initial clear_tables();

    always @(posedge aclk) begin
        read_result_t e;
        if (!aresetn) begin
            clear_tables();
            expected_reads.delete();
            errors <= 0;
        end else begin
            // compare a taken result against the oldest prediction
            if (m_valid && m_ready) begin
                if (expected_reads.size() == 0) begin
                    $display("%0t: unexpected result count=%0d", $time, m_bin_count);
                    errors <= errors + 1;
                end else begin
                    e = expected_reads.pop_front();
                    if (m_bin_count !== e.count || m_percent !== e.pct ||
                        m_total_bytes !== e.total || m_status !== e.status) begin
                        $display("%0t: mismatch expected cnt=%0d pct=%0d tot=%0d st=%0d",
                                 $time, e.count, e.pct, e.total, e.status);
                        $display("%0t:          actual   cnt=%0d pct=%0d tot=%0d st=%0d",
                                 $time, m_bin_count, m_percent, m_total_bytes, m_status);
                        errors <= errors + 1;
                    end
                end
            end
            // update prediction on each accepted request
            if (s_valid && s_ready) begin
                case (s_cmd)
                    bnph_pkg::CMD_COUNT: begin
                        lo_nib_cnt[s_data_byte[3:0]] = sat_inc(lo_nib_cnt[s_data_byte[3:0]]);
                        hi_nib_cnt[s_data_byte[7:4]] = sat_inc(hi_nib_cnt[s_data_byte[7:4]]);
                        byte_cnt[s_data_byte] = sat_inc(byte_cnt[s_data_byte]);
                        if (odd_pos) begin
                            plo_cnt[open_low] = sat_inc(plo_cnt[open_low]);
                            phi_cnt[s_data_byte] = sat_inc(phi_cnt[s_data_byte]);
                        end else begin
                            open_low = s_data_byte;
                        end
                        odd_pos = ~odd_pos;
                        total_cnt = sat_inc(total_cnt);
                    end
                    bnph_pkg::CMD_READ:
                        expected_reads.push_back(predict_read(s_table_sel, s_bin_index));
                    bnph_pkg::CMD_CLEAR: clear_tables();
                    default: ;
                endcase
            end
        end
    end

endmodule

/* tb/sv/tb.sv */
// Testbench top: request stimulus, clock, reset and verdict for the histogram.
`timescale 1ns / 100ps
module tb;

    localparam int N_RANDOM  = 1800;
    localparam int WDOG_MAX  = 20000;
    localparam int DRAIN_CYC = 300;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_cmd = bnph_pkg::CMD_COUNT;
    logic [7:0]  s_data_byte = '0;
    logic [2:0]  s_table_sel = bnph_pkg::SEL_LO_NIB;
    logic [7:0]  s_bin_index = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_bin_count;
    logic [14:0] m_percent;
    logic [31:0] m_total_bytes;
    logic [1:0]  m_status;
    int          errors;
    int          pending;
    logic        quiet = 1'b0;
    int          idle_cycles = 0;

    always #2 aclk = ~aclk;

    byte_nibble_pair_histogram_top dut (.*);
    histogram_checker chk (.*);

    // receiver: random stall bursts until the quiet tail
    initial begin
        int n;
        @(posedge aclk);
        forever begin
            if (!quiet && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                n = $urandom_range(1, 12);
                repeat (n) @(posedge aclk);
            end
            m_ready <= 1'b1;
            n = $urandom_range(1, 20);
            repeat (n) @(posedge aclk);
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_MAX) begin
            $display("FAIL");
            $finish;
        end
    end

    // drive one request and hold it until accepted
    task automatic send_req(logic [1:0] c, logic [7:0] d, logic [2:0] t, logic [7:0] b);
        int n;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            n = $urandom_range(1, 12);
            repeat (n) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_cmd       <= c;
        s_data_byte <= d;
        s_table_sel <= t;
        s_bin_index <= b;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_random();
        int          k;
        logic [2:0]  t;
        k = $urandom_range(0, 99);
        t = 3'($urandom_range(0, 7));
        if (k < 65)
            send_req(bnph_pkg::CMD_COUNT, 8'($urandom), 3'($urandom), 8'($urandom));
        else if (k < 93)
            send_req(bnph_pkg::CMD_READ, 8'($urandom), t,
                     ($urandom_range(0, 3) == 0 || t >= bnph_pkg::SEL_BYTE) ?
                     8'($urandom) : 8'($urandom_range(0, 15)));
        else if (k < 95)
            send_req(bnph_pkg::CMD_CLEAR, 8'($urandom), 3'($urandom), 8'($urandom));
        else if (k < 97)
            send_req(CMD_UNUSED, 8'($urandom), 3'($urandom), 8'($urandom));
        else
            send_req(bnph_pkg::CMD_COUNT, 8'($urandom_range(0, 1) ? 8'h00 : 8'hFF),
                     3'($urandom), 8'($urandom));
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: zero-total reads, bad bins, extremes, odd trailing byte
        send_req(bnph_pkg::CMD_READ, 8'h00, bnph_pkg::SEL_LO_NIB, 8'd0);
        send_req(bnph_pkg::CMD_READ, 8'h00, bnph_pkg::SEL_PAIR_HI, 8'd255);
        send_req(bnph_pkg::CMD_READ, 8'h00, bnph_pkg::SEL_HI_NIB, 8'd16);
        send_req(bnph_pkg::CMD_READ, 8'h00, 3'd7, 8'd0);
        send_req(bnph_pkg::CMD_COUNT, 8'h00, bnph_pkg::SEL_LO_NIB, 8'd0);
        send_req(bnph_pkg::CMD_COUNT, 8'hFF, bnph_pkg::SEL_LO_NIB, 8'd0);
        send_req(bnph_pkg::CMD_COUNT, 8'hA5, bnph_pkg::SEL_LO_NIB, 8'd0);
        send_req(CMD_UNUSED, 8'h5A, 3'd7, 8'hFF);
        send_req(bnph_pkg::CMD_READ, 8'h00, bnph_pkg::SEL_LO_NIB, 8'd15);
        send_req(bnph_pkg::CMD_READ, 8'h00, bnph_pkg::SEL_HI_NIB, 8'd10);
        send_req(bnph_pkg::CMD_READ, 8'h00, bnph_pkg::SEL_BYTE, 8'd255);
        send_req(bnph_pkg::CMD_READ, 8'h00, bnph_pkg::SEL_PAIR_LO, 8'd0);
        send_req(bnph_pkg::CMD_READ, 8'h00, bnph_pkg::SEL_PAIR_HI, 8'd255);
        send_req(bnph_pkg::CMD_READ, 8'h00, bnph_pkg::SEL_PAIR_LO, 8'hA5);
        send_req(bnph_pkg::CMD_READ, 8'h00, 3'd5, 8'd3);
        send_req(bnph_pkg::CMD_READ, 8'h00, bnph_pkg::SEL_LO_NIB, 8'd200);
        send_req(bnph_pkg::CMD_CLEAR, 8'h00, bnph_pkg::SEL_LO_NIB, 8'd0);
        send_req(bnph_pkg::CMD_READ, 8'h00, bnph_pkg::SEL_BYTE, 8'd0);

        // hold off until every result has drained
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM - 200) quiet = 1'b1;
            send_random();
        end
        s_valid <= 1'b0;

        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
